// File: design/acft_pkg.sv
`timescale 1ns / 1ps

package acft_pkg;

	localparam int COEF_W = 32;
	localparam int COORD_W = 48;
	localparam int DIFF_W = COORD_W + 1;
	localparam int LO_W = 25;
	localparam int PROD_W = COEF_W + DIFF_W;
	localparam int SUM_W = PROD_W + 1;
	localparam int DET_W = 2 * COEF_W + 1;
	localparam int MAG_W = SUM_W - 1;
	localparam int QUOT_W = 51;
	localparam int DIV_W = 2 * COEF_W;
	localparam int CFG_IDX_W = 3;

	localparam int COEF_FRAC_BITS_DEF = 28;

	localparam logic [QUOT_W-1:0] MAG_CLAMP = {1'b1, {(QUOT_W-1){1'b0}}};
	localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	localparam logic MODE_INVERSE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_XX,
		REG_COEF_XY,
		REG_COEF_YX,
		REG_COEF_YY,
		REG_TARGET_ORIGIN_X,
		REG_TARGET_ORIGIN_Y,
		REG_SOURCE_ORIGIN_X,
		REG_SOURCE_ORIGIN_Y
	} acft_reg_t;

	typedef struct packed {
		logic inv;
		logic undef;
		logic [COORD_W-1:0] x_in;
		logic [COORD_W-1:0] y_in;
	} acft_item_t;

	typedef struct packed {
		acft_item_t item;
		logic sing;
		logic ovf_x;
		logic ovf_y;
		logic neg_x;
		logic neg_y;
		logic [QUOT_W-1:0] fmag_x;
		logic [QUOT_W-1:0] fmag_y;
	} acft_side_t;

endpackage

// File: design/affine_coordinate_transform_2d_unit.sv
// Pipeline: a request passes 59 register stages: 6 arithmetic, 51 restoring divider
// steps of one quotient bit, rounding, output.
// Throughput: one request per cycle; the whole pipeline holds while a result is stalled.
// Reset: all valid bits clear; matrix resets to identity, origins to zero.
// No clearing pass; requests are taken from the first cycle after reset.
`timescale 1ns / 1ps

module affine_coordinate_transform_2d_unit #(
	parameter int COEF_FRAC_BITS = acft_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic mode,
	input  logic signed [acft_pkg::COORD_W-1:0] x_in,
	input  logic signed [acft_pkg::COORD_W-1:0] y_in,
	input  logic in_undefined,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [acft_pkg::COORD_W-1:0] x_out,
	output logic signed [acft_pkg::COORD_W-1:0] y_out,
	output logic out_undefined,
	output logic saturated,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [acft_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [acft_pkg::COORD_W-1:0] cfg_data
);

	localparam int CW = acft_pkg::COEF_W;
	localparam int XW = acft_pkg::COORD_W;
	localparam int SW = acft_pkg::SUM_W;
	localparam int MW = acft_pkg::MAG_W;
	localparam int TW = acft_pkg::DET_W;
	localparam int QW = acft_pkg::QUOT_W;
	localparam int DW = acft_pkg::DIV_W;
	localparam int NW = MW + COEF_FRAC_BITS;
	localparam int RW = QW + 2;
	localparam logic [DW-1:0] DET_MIN =
		DW'((64'd1 << (2 * COEF_FRAC_BITS)) / 64'd1000000000000);
	localparam logic [MW-1:0] HALF = MW'(1) << (COEF_FRAC_BITS - 1);
	localparam logic [CW-1:0] COEF_ONE = CW'(1) << COEF_FRAC_BITS;

	logic en;

	// configuration registers
	logic signed [CW-1:0] coef_xx_q, coef_xy_q, coef_yx_q, coef_yy_q;
	logic [XW-1:0] tgt_x_q, tgt_y_q, src_x_q, src_y_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q <= COEF_ONE;
			coef_xy_q <= '0;
			coef_yx_q <= '0;
			coef_yy_q <= COEF_ONE;
			tgt_x_q <= '0;
			tgt_y_q <= '0;
			src_x_q <= '0;
			src_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (acft_pkg::acft_reg_t'(cfg_index))
				acft_pkg::REG_COEF_XX: coef_xx_q <= cfg_data[CW-1:0];
				acft_pkg::REG_COEF_XY: coef_xy_q <= cfg_data[CW-1:0];
				acft_pkg::REG_COEF_YX: coef_yx_q <= cfg_data[CW-1:0];
				acft_pkg::REG_COEF_YY: coef_yy_q <= cfg_data[CW-1:0];
				acft_pkg::REG_TARGET_ORIGIN_X: tgt_x_q <= cfg_data;
				acft_pkg::REG_TARGET_ORIGIN_Y: tgt_y_q <= cfg_data;
				acft_pkg::REG_SOURCE_ORIGIN_X: src_x_q <= cfg_data;
				acft_pkg::REG_SOURCE_ORIGIN_Y: src_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless a held result is stalled
	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	acft_pkg::acft_item_t in_item;
	assign in_item.inv = (mode == acft_pkg::MODE_INVERSE);
	assign in_item.undef = in_undefined;
	assign in_item.x_in = x_in;
	assign in_item.y_in = y_in;

	logic v_s4;
	acft_pkg::acft_item_t item_s4;
	logic signed [SW-1:0] sum_x_s4, sum_y_s4;
	logic signed [TW-1:0] det_s4;

	acft_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (in_valid),
		.in_item  (in_item),
		.c_xx     (coef_xx_q),
		.c_xy     (coef_xy_q),
		.c_yx     (coef_yx_q),
		.c_yy     (coef_yy_q),
		.org_tx   (tgt_x_q),
		.org_ty   (tgt_y_q),
		.org_sx   (src_x_q),
		.org_sy   (src_y_q),
		.out_v    (v_s4),
		.out_item (item_s4),
		.sum_x    (sum_x_s4),
		.sum_y    (sum_y_s4),
		.det      (det_s4)
	);

	// stage 5: magnitudes and signs
	logic v_s5;
	acft_pkg::acft_item_t item_s5;
	logic [MW-1:0] mag_x_s5, mag_y_s5;
	logic neg_x_s5, neg_y_s5, dneg_s5;
	logic [DW-1:0] dm_s5;
	logic [SW-1:0] ax, ay;
	logic [TW-1:0] ad;

	always_comb begin
		ax = sum_x_s4[SW-1] ? -sum_x_s4 : sum_x_s4;
		ay = sum_y_s4[SW-1] ? -sum_y_s4 : sum_y_s4;
		ad = det_s4[TW-1] ? -det_s4 : det_s4;
	end

	// stage 6: forward rounding, singular test, divider set-up
	logic v_s6;
	acft_pkg::acft_side_t side_s6, side_n;
	logic [DW-1:0] div_s6, rem_x_s6, rem_y_s6;
	logic [QW-1:0] lo_x_s6, lo_y_s6;
	logic [NW-1:0] nx, ny;
	logic [MW-1:0] fr_x, fr_y, sh_x, sh_y;

	always_comb begin
		nx = {mag_x_s5, {COEF_FRAC_BITS{1'b0}}};
		ny = {mag_y_s5, {COEF_FRAC_BITS{1'b0}}};
		fr_x = mag_x_s5 + HALF;
		fr_y = mag_y_s5 + HALF;
		sh_x = fr_x >> COEF_FRAC_BITS;
		sh_y = fr_y >> COEF_FRAC_BITS;
		side_n.item = item_s5;
		side_n.sing = dm_s5 <= DET_MIN;
		side_n.ovf_x = DW'(nx[NW-1:QW]) >= dm_s5;
		side_n.ovf_y = DW'(ny[NW-1:QW]) >= dm_s5;
		side_n.neg_x = neg_x_s5 ^ (item_s5.inv & dneg_s5);
		side_n.neg_y = neg_y_s5 ^ (item_s5.inv & dneg_s5);
		side_n.fmag_x = (|sh_x[MW-1:QW]) ? acft_pkg::MAG_CLAMP : sh_x[QW-1:0];
		side_n.fmag_y = (|sh_y[MW-1:QW]) ? acft_pkg::MAG_CLAMP : sh_y[QW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s5 <= item_s4;
			mag_x_s5 <= ax[MW-1:0];
			mag_y_s5 <= ay[MW-1:0];
			neg_x_s5 <= sum_x_s4[SW-1];
			neg_y_s5 <= sum_y_s4[SW-1];
			dm_s5 <= ad[DW-1:0];
			dneg_s5 <= det_s4[TW-1];

			side_s6 <= side_n;
			div_s6 <= dm_s5;
			rem_x_s6 <= DW'(nx[NW-1:QW]);
			rem_y_s6 <= DW'(ny[NW-1:QW]);
			lo_x_s6 <= nx[QW-1:0];
			lo_y_s6 <= ny[QW-1:0];
		end
	end

	logic v_dv;
	acft_pkg::acft_side_t side_dv;
	logic [DW-1:0] div_dv, rem_x_dv, rem_y_dv;
	logic [QW-1:0] q_x_dv, q_y_dv;

	acft_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_v      (v_s6),
		.in_side   (side_s6),
		.in_div    (div_s6),
		.in_rem_x  (rem_x_s6),
		.in_rem_y  (rem_y_s6),
		.in_lo_x   (lo_x_s6),
		.in_lo_y   (lo_y_s6),
		.out_v     (v_dv),
		.out_side  (side_dv),
		.out_div   (div_dv),
		.out_rem_x (rem_x_dv),
		.out_rem_y (rem_y_dv),
		.out_q_x   (q_x_dv),
		.out_q_y   (q_y_dv)
	);

	// final magnitude: round the quotient in inverse mode, clamp to 2^50 in both modes
	logic v_f1;
	acft_pkg::acft_side_t side_f1;
	logic [QW-1:0] m_x_f1, m_y_f1, m_x, m_y;
	logic rnd_x, rnd_y;
	logic [DW:0] dext;

	always_comb begin
		dext = {1'b0, div_dv};
		rnd_x = {rem_x_dv, 1'b0} >= dext;
		rnd_y = {rem_y_dv, 1'b0} >= dext;
		if (side_dv.item.inv) begin
			if (side_dv.ovf_x || q_x_dv > acft_pkg::MAG_CLAMP
					|| (q_x_dv == acft_pkg::MAG_CLAMP && rnd_x)) begin
				m_x = acft_pkg::MAG_CLAMP;
			end else begin
				m_x = q_x_dv + QW'(rnd_x);
			end
			if (side_dv.ovf_y || q_y_dv > acft_pkg::MAG_CLAMP
					|| (q_y_dv == acft_pkg::MAG_CLAMP && rnd_y)) begin
				m_y = acft_pkg::MAG_CLAMP;
			end else begin
				m_y = q_y_dv + QW'(rnd_y);
			end
		end else begin
			m_x = (side_dv.fmag_x > acft_pkg::MAG_CLAMP) ? acft_pkg::MAG_CLAMP
				: side_dv.fmag_x;
			m_y = (side_dv.fmag_y > acft_pkg::MAG_CLAMP) ? acft_pkg::MAG_CLAMP
				: side_dv.fmag_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
		end else if (en) begin
			v_f1 <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_f1 <= side_dv;
			m_x_f1 <= m_x;
			m_y_f1 <= m_y;
		end
	end

	// output stage: add origin, saturate, apply special cases
	logic out_valid_q, out_undef_q, sat_q;
	logic [XW-1:0] x_out_q, y_out_q;
	logic [XW-1:0] org_x, org_y, res_x, res_y;
	logic signed [RW-1:0] ox_e, oy_e, mx_e, my_e, r_x, r_y;
	logic ovr_x, ovr_y;

	always_comb begin
		org_x = side_f1.item.inv ? src_x_q : tgt_x_q;
		org_y = side_f1.item.inv ? src_y_q : tgt_y_q;
		ox_e = $signed({{(RW-XW){org_x[XW-1]}}, org_x});
		oy_e = $signed({{(RW-XW){org_y[XW-1]}}, org_y});
		mx_e = $signed({{(RW-QW){1'b0}}, m_x_f1});
		my_e = $signed({{(RW-QW){1'b0}}, m_y_f1});
		r_x = side_f1.neg_x ? ox_e - mx_e : ox_e + mx_e;
		r_y = side_f1.neg_y ? oy_e - my_e : oy_e + my_e;
		ovr_x = !((&r_x[RW-1:XW-1]) || !(|r_x[RW-1:XW-1]));
		ovr_y = !((&r_y[RW-1:XW-1]) || !(|r_y[RW-1:XW-1]));
		res_x = ovr_x ? (r_x[RW-1] ? acft_pkg::SAT_MIN : acft_pkg::SAT_MAX) : r_x[XW-1:0];
		res_y = ovr_y ? (r_y[RW-1] ? acft_pkg::SAT_MIN : acft_pkg::SAT_MAX) : r_y[XW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_f1.item.undef) begin
				x_out_q <= side_f1.item.x_in;
				y_out_q <= side_f1.item.y_in;
				out_undef_q <= 1'b1;
				sat_q <= 1'b0;
			end else if (side_f1.item.inv && side_f1.sing) begin
				x_out_q <= '0;
				y_out_q <= '0;
				out_undef_q <= 1'b1;
				sat_q <= 1'b0;
			end else begin
				x_out_q <= res_x;
				y_out_q <= res_y;
				out_undef_q <= 1'b0;
				sat_q <= ovr_x || ovr_y;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign x_out = x_out_q;
	assign y_out = y_out_q;
	assign out_undefined = out_undef_q;
	assign saturated = sat_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output register free");

	a_undef_not_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_undefined && saturated))
		else $error("undefined result flagged saturated");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (x_out == acft_pkg::SAT_MAX
			|| x_out == acft_pkg::SAT_MIN || y_out == acft_pkg::SAT_MAX
			|| y_out == acft_pkg::SAT_MIN))
		else $error("saturated result not at a limit");

endmodule

// File: design/acft_front.sv
`timescale 1ns / 1ps

module acft_front (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  acft_pkg::acft_item_t in_item,
	input  logic signed [acft_pkg::COEF_W-1:0] c_xx,
	input  logic signed [acft_pkg::COEF_W-1:0] c_xy,
	input  logic signed [acft_pkg::COEF_W-1:0] c_yx,
	input  logic signed [acft_pkg::COEF_W-1:0] c_yy,
	input  logic [acft_pkg::COORD_W-1:0] org_tx,
	input  logic [acft_pkg::COORD_W-1:0] org_ty,
	input  logic [acft_pkg::COORD_W-1:0] org_sx,
	input  logic [acft_pkg::COORD_W-1:0] org_sy,
	output logic out_v,
	output acft_pkg::acft_item_t out_item,
	output logic signed [acft_pkg::SUM_W-1:0] sum_x,
	output logic signed [acft_pkg::SUM_W-1:0] sum_y,
	output logic signed [acft_pkg::DET_W-1:0] det
);

	localparam int CW = acft_pkg::COEF_W;
	localparam int XW = acft_pkg::COORD_W;
	localparam int DW = acft_pkg::DIFF_W;
	localparam int LW = acft_pkg::LO_W;
	localparam int PW = acft_pkg::PROD_W;
	localparam int SW = acft_pkg::SUM_W;
	localparam int TW = acft_pkg::DET_W;
	localparam int PLW = CW + LW + 1;
	localparam int PHW = CW + DW - LW;

	logic v_s1, v_s2, v_s3, v_s4;
	acft_pkg::acft_item_t item_s1, item_s2, item_s3, item_s4;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [PLW-1:0] pl_s2 [4];
	logic signed [PHW-1:0] ph_s2 [4];
	logic signed [2*CW-1:0] pd_s2 [2];
	logic signed [PW-1:0] p_s3 [4];
	logic signed [TW-1:0] det_s3, det_s4;
	logic signed [SW-1:0] sum_x_s4, sum_y_s4;

	logic [XW-1:0] ox, oy;
	logic signed [CW-1:0] cm [4];
	logic signed [DW-1:0] dd [4];

	always_comb begin
		ox = in_item.inv ? org_tx : org_sx;
		oy = in_item.inv ? org_ty : org_sy;
		cm[0] = item_s1.inv ? c_yy : c_xx;
		cm[1] = c_xy;
		cm[2] = c_yx;
		cm[3] = item_s1.inv ? c_xx : c_yy;
		dd[0] = dx_s1;
		dd[1] = dy_s1;
		dd[2] = dx_s1;
		dd[3] = dy_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			dx_s1 <= $signed({in_item.x_in[XW-1], in_item.x_in}) - $signed({ox[XW-1], ox});
			dy_s1 <= $signed({in_item.y_in[XW-1], in_item.y_in}) - $signed({oy[XW-1], oy});

			// split each coordinate product into two narrow partial products
			item_s2 <= item_s1;
			for (int i = 0; i < 4; i++) begin
				pl_s2[i] <= cm[i] * $signed({1'b0, dd[i][LW-1:0]});
				ph_s2[i] <= cm[i] * $signed(dd[i][DW-1:LW]);
			end
			pd_s2[0] <= c_xx * c_yy;
			pd_s2[1] <= c_xy * c_yx;

			item_s3 <= item_s2;
			for (int i = 0; i < 4; i++) begin
				p_s3[i] <= (PW'(ph_s2[i]) <<< LW) + PW'(pl_s2[i]);
			end
			det_s3 <= TW'(pd_s2[0]) - TW'(pd_s2[1]);

			item_s4 <= item_s3;
			det_s4 <= det_s3;
			sum_x_s4 <= item_s3.inv ? SW'(p_s3[0]) - SW'(p_s3[1])
				: SW'(p_s3[0]) + SW'(p_s3[1]);
			sum_y_s4 <= item_s3.inv ? SW'(p_s3[3]) - SW'(p_s3[2])
				: SW'(p_s3[2]) + SW'(p_s3[3]);
		end
	end

	assign out_v = v_s4;
	assign out_item = item_s4;
	assign sum_x = sum_x_s4;
	assign sum_y = sum_y_s4;
	assign det = det_s4;

endmodule

// File: design/acft_div.sv
`timescale 1ns / 1ps

module acft_div (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  acft_pkg::acft_side_t in_side,
	input  logic [acft_pkg::DIV_W-1:0] in_div,
	input  logic [acft_pkg::DIV_W-1:0] in_rem_x,
	input  logic [acft_pkg::DIV_W-1:0] in_rem_y,
	input  logic [acft_pkg::QUOT_W-1:0] in_lo_x,
	input  logic [acft_pkg::QUOT_W-1:0] in_lo_y,
	output logic out_v,
	output acft_pkg::acft_side_t out_side,
	output logic [acft_pkg::DIV_W-1:0] out_div,
	output logic [acft_pkg::DIV_W-1:0] out_rem_x,
	output logic [acft_pkg::DIV_W-1:0] out_rem_y,
	output logic [acft_pkg::QUOT_W-1:0] out_q_x,
	output logic [acft_pkg::QUOT_W-1:0] out_q_y
);

	localparam int N = acft_pkg::QUOT_W;
	localparam int DW = acft_pkg::DIV_W;

	// stage k holds the partial remainder; the low word shifts dividend bits
	// out at the top and quotient bits in at the bottom
	logic v_s [1:N];
	acft_pkg::acft_side_t side_s [1:N];
	logic [DW-1:0] div_s [1:N];
	logic [DW-1:0] rem_x_s [1:N];
	logic [DW-1:0] rem_y_s [1:N];
	logic [N-1:0] lo_x_s [1:N];
	logic [N-1:0] lo_y_s [1:N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic src_v;
		acft_pkg::acft_side_t src_side;
		logic [DW-1:0] src_div, src_rx, src_ry;
		logic [N-1:0] src_lx, src_ly;
		logic [DW:0] t_x, t_y, dext;
		logic ge_x, ge_y;

		if (k == 0) begin : g_first
			assign src_v = in_v;
			assign src_side = in_side;
			assign src_div = in_div;
			assign src_rx = in_rem_x;
			assign src_ry = in_rem_y;
			assign src_lx = in_lo_x;
			assign src_ly = in_lo_y;
		end else begin : g_next
			assign src_v = v_s[k];
			assign src_side = side_s[k];
			assign src_div = div_s[k];
			assign src_rx = rem_x_s[k];
			assign src_ry = rem_y_s[k];
			assign src_lx = lo_x_s[k];
			assign src_ly = lo_y_s[k];
		end

		always_comb begin
			dext = {1'b0, src_div};
			t_x = {src_rx, src_lx[N-1]};
			t_y = {src_ry, src_ly[N-1]};
			ge_x = t_x >= dext;
			ge_y = t_y >= dext;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= src_side;
				div_s[k+1] <= src_div;
				rem_x_s[k+1] <= ge_x ? DW'(t_x - dext) : t_x[DW-1:0];
				rem_y_s[k+1] <= ge_y ? DW'(t_y - dext) : t_y[DW-1:0];
				lo_x_s[k+1] <= {src_lx[N-2:0], ge_x};
				lo_y_s[k+1] <= {src_ly[N-2:0], ge_y};
			end
		end
	end

	assign out_v = v_s[N];
	assign out_side = side_s[N];
	assign out_div = div_s[N];
	assign out_rem_x = rem_x_s[N];
	assign out_rem_y = rem_y_s[N];
	assign out_q_x = lo_x_s[N];
	assign out_q_y = lo_y_s[N];

endmodule
